// File: hw/rtl/isfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_pkg: IMU serial frame parser package
// Byte codes of the sensor frame, kind codes of a result and the parser
// phase encoding.
// ----------------------------------------------------------------------------
package isfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned PAY_N   = 5;
    localparam int unsigned PAY_IDX_W = $clog2(PAY_N);

    localparam logic [BYTE_W-1:0] HDR_BYTE    = 8'h5A;
    localparam logic [BYTE_W-1:0] KIND_EULER  = 8'h45;
    localparam logic [BYTE_W-1:0] KIND_GYRO   = 8'h25;
    localparam logic [BYTE_W-1:0] KIND_ACCEL  = 8'h15;
    localparam logic [BYTE_W-1:0] FRAME_LEN   = 8'h06;

    typedef logic [BYTE_W-1:0]         byte_t;
    typedef logic [PAY_IDX_W-1:0]      pay_idx_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CODE_EULER = 2'd0,
        KIND_CODE_GYRO  = 2'd1,
        KIND_CODE_ACCEL = 2'd2,
        KIND_CODE_SPARE = 2'd3
    } kind_t;

    typedef enum logic [9:0] {
        PH_HUNT0   = 10'b00_0000_0001,
        PH_HUNT1   = 10'b00_0000_0010,
        PH_KIND    = 10'b00_0000_0100,
        PH_LEN     = 10'b00_0000_1000,
        PH_PAY0    = 10'b00_0001_0000,
        PH_PAY1    = 10'b00_0010_0000,
        PH_PAY2    = 10'b00_0100_0000,
        PH_PAY3    = 10'b00_1000_0000,
        PH_PAY4    = 10'b01_0000_0000,
        PH_PAYLAST = 10'b10_0000_0000
    } phase_t;

endpackage

// File: hw/rtl/imu_serial_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser: IMU serial frame parser
// Hunts for sensor frames in a stream of received serial bytes and emits
// the kind and three signed axis values of each complete frame.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer, and a byte can be taken in every
// cycle while the input does not stall. Each byte is held in an input
// register, then the phase register, the payload store and, on the last
// payload byte of a frame, the result register are updated, so a result is
// offered from the result register once the byte that completes its frame
// has left the input register. A frame header
// is two 0x5A bytes, a kind byte (0x45 Euler, 0x25 gyro, 0x15 accel) and a
// length byte of 6, followed by six payload bytes holding three big-endian
// signed values in hundredths of a unit; the checksum is not examined. Any
// mismatch drops the byte and returns to header hunting. The input stalls
// only while the result register is full and stalled and the held byte is
// the last of a frame.
module imu_serial_frame_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  isfp_pkg::byte_t      rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output isfp_pkg::kind_t      frame_kind,
    output isfp_pkg::value_t     value_x,
    output isfp_pkg::value_t     value_y,
    output isfp_pkg::value_t     value_z
);
    import isfp_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    byte_t    rx_reg;
    phase_t   phase_reg;
    phase_t   phase_next;
    kind_t    kind_reg;
    kind_t    kind_next;
    byte_t    pay_reg [PAY_N];
    logic     pay_we;
    pay_idx_t pay_idx;
    logic     out_valid_reg;
    logic     out_valid_next;
    kind_t    out_kind_reg;
    value_t   out_x_reg;
    value_t   out_y_reg;
    value_t   out_z_reg;

    logic     in_xfer;
    logic     out_free;
    logic     emit;
    logic     advance;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = in_valid_reg && (phase_reg == PH_PAYLAST);
    assign advance  = in_valid_reg && (!emit || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        pay_we     = 1'b0;
        pay_idx    = '0;
        unique case (phase_reg)
            PH_HUNT1:
            begin
                phase_next = (rx_reg == HDR_BYTE) ? PH_KIND : PH_HUNT0;
            end
            PH_KIND:
            begin
                priority if (rx_reg == KIND_EULER)
                begin
                    kind_next  = KIND_CODE_EULER;
                    phase_next = PH_LEN;
                end
                else if (rx_reg == KIND_GYRO)
                begin
                    kind_next  = KIND_CODE_GYRO;
                    phase_next = PH_LEN;
                end
                else if (rx_reg == KIND_ACCEL)
                begin
                    kind_next  = KIND_CODE_ACCEL;
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next = PH_HUNT0;
                end
            end
            PH_LEN:
            begin
                phase_next = (rx_reg == FRAME_LEN) ? PH_PAY0 : PH_HUNT0;
            end
            PH_PAY0:
            begin
                pay_we     = 1'b1;
                pay_idx    = PAY_IDX_W'(0);
                phase_next = PH_PAY1;
            end
            PH_PAY1:
            begin
                pay_we     = 1'b1;
                pay_idx    = PAY_IDX_W'(1);
                phase_next = PH_PAY2;
            end
            PH_PAY2:
            begin
                pay_we     = 1'b1;
                pay_idx    = PAY_IDX_W'(2);
                phase_next = PH_PAY3;
            end
            PH_PAY3:
            begin
                pay_we     = 1'b1;
                pay_idx    = PAY_IDX_W'(3);
                phase_next = PH_PAY4;
            end
            PH_PAY4:
            begin
                pay_we     = 1'b1;
                pay_idx    = PAY_IDX_W'(4);
                phase_next = PH_PAYLAST;
            end
            PH_PAYLAST:
            begin
                phase_next = PH_HUNT0;
            end
            default:
            begin
                phase_next = (rx_reg == HDR_BYTE) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    end

    always_comb
    begin
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_HUNT0;
            kind_reg      <= KIND_CODE_EULER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            rx_reg <= rx_byte;
        end
        if (advance && pay_we)
        begin
            pay_reg[pay_idx] <= rx_reg;
        end
        if (advance && emit)
        begin
            out_kind_reg <= kind_reg;
            out_x_reg    <= value_t'({pay_reg[0], pay_reg[1]});
            out_y_reg    <= value_t'({pay_reg[2], pay_reg[3]});
            out_z_reg    <= value_t'({pay_reg[4], rx_reg});
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_kind = out_kind_reg;
    assign value_x    = out_x_reg;
    assign value_y    = out_y_reg;
    assign value_z    = out_z_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (emit && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> (out_valid && phase_reg == PH_HUNT0))
        else $error("frame end did not load a result and restart hunting");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(advance && emit))
        else $error("result offered without a completed frame");

    a_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_LEN && rx_reg != FRAME_LEN)
        |=> (phase_reg == PH_HUNT0))
        else $error("bad length byte did not restart hunting");

    a_kind_held: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_KIND && rx_reg == KIND_ACCEL)
        |=> (kind_reg == KIND_CODE_ACCEL && phase_reg == PH_LEN))
        else $error("accel kind byte not held");

endmodule
